// File: rtl/tflc_pkg.sv
// ----------------------------------------------------------------------------
// tflc_pkg
// Types and constants shared by the thermal fan level controller.
// ----------------------------------------------------------------------------
package tflc_pkg;

	localparam int TEMP_W  = 9;
	localparam int LEVEL_W = 10;
	localparam int RISE_W  = 4;
	localparam int CHG_W   = 10;
	localparam int CALC_W  = 14;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [LEVEL_W-1:0] BASE_LEVEL     = 10'd128;
	localparam logic signed [TEMP_W-1:0] FAN_START_TEMP = 9'sd45;
	localparam logic signed [CALC_W-1:0] EXCESS_GAIN    = 14'sd15;
	localparam logic signed [CALC_W-1:0] CHANGE_GAIN    = 14'sd5;
	localparam logic [RISE_W-1:0]  RISE_LIMIT     = 4'd10;

	localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST  = 10'd255;
	localparam logic               UPD_EN_RST     = 1'b1;

	localparam logic REG_MAX_LEVEL = 1'b0;
	localparam logic REG_UPD_EN    = 1'b1;

	typedef struct packed {
		logic [LEVEL_W-1:0] max_level;
		logic               update_enable;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]       fan_level;
		logic [RISE_W-1:0]        rise_count;
		logic signed [TEMP_W-1:0] previous_temp;
		logic                     previous_valid;
		logic signed [CHG_W-1:0]  last_change;
		logic                     pwm_running;
	} state_t;

	localparam state_t STATE_RST = '{
		fan_level:      '0,
		rise_count:     '0,
		previous_temp:  '0,
		previous_valid: 1'b0,
		last_change:    '1,
		pwm_running:    1'b0
	};

	typedef struct packed {
		logic               fan_on;
		logic [LEVEL_W-1:0] pwm_threshold;
		logic               boost_enable;
		logic               stop_old_pwm;
	} result_t;

endpackage

// File: rtl/tflc_apb_regs.sv
// ----------------------------------------------------------------------------
// tflc_apb_regs
// APB register file: max_level and update_enable.
// ----------------------------------------------------------------------------
module tflc_apb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tflc_pkg::APB_AW-1:0]    paddr,
	input  logic [tflc_pkg::APB_DW-1:0]    pwdata,
	output logic [tflc_pkg::APB_DW-1:0]    prdata,
	output logic                           pready,
	output tflc_pkg::cfg_t                 cfg
);
	import tflc_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_level     <= MAX_LEVEL_RST;
			cfg_q.update_enable <= UPD_EN_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_MAX_LEVEL: cfg_q.max_level     <= pwdata[LEVEL_W-1:0];
				REG_UPD_EN:    cfg_q.update_enable <= pwdata[0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_MAX_LEVEL: prdata = {{(APB_DW-LEVEL_W){1'b0}}, cfg_q.max_level};
			REG_UPD_EN:    prdata = {{(APB_DW-1){1'b0}}, cfg_q.update_enable};
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/tflc_level_calc.sv
// ----------------------------------------------------------------------------
// tflc_level_calc
// Next fan level, rise counter and drive result for one control tick.
// ----------------------------------------------------------------------------
module tflc_level_calc (
	input  tflc_pkg::cfg_t                      cfg,
	input  tflc_pkg::state_t                    state_cur,
	input  logic signed [tflc_pkg::TEMP_W-1:0]  temp_a,
	input  logic signed [tflc_pkg::TEMP_W-1:0]  temp_b,
	input  logic signed [tflc_pkg::TEMP_W-1:0]  temp_c,
	input  logic                                system_active,
	output tflc_pkg::state_t                    state_next,
	output tflc_pkg::result_t                   res,
	output logic                                emit
);
	import tflc_pkg::*;

	logic signed [TEMP_W-1:0] cur_ab;
	logic signed [TEMP_W-1:0] cur;
	logic                     excess_nz;
	logic [7:0]               excess;
	logic signed [CHG_W-1:0]  diff;
	logic signed [CHG_W-1:0]  lc_new;
	logic signed [CALC_W-1:0] excess_ext;
	logic signed [CALC_W-1:0] lc_ext;
	logic signed [CALC_W-1:0] rise_ext;
	logic signed [CALC_W-1:0] lvl_calc;
	logic signed [CALC_W-1:0] lvl;
	logic signed [CALC_W-1:0] max_ext;
	logic [LEVEL_W-1:0]       level_new;
	logic [RISE_W-1:0]        rise_new;
	logic [LEVEL_W-1:0]       drv_level;
	logic                     drv_req;
	logic                     full_on;

	assign cur_ab    = (temp_b > temp_a) ? temp_b : temp_a;
	assign cur       = (temp_c > cur_ab) ? temp_c : cur_ab;
	assign excess_nz = cur > FAN_START_TEMP;
	assign excess    = 8'(cur - FAN_START_TEMP);
	assign diff      = {cur[TEMP_W-1], cur} - {state_cur.previous_temp[TEMP_W-1],
		state_cur.previous_temp};
	assign lc_new    = (cur != state_cur.previous_temp) ? diff : state_cur.last_change;

	assign excess_ext = {6'b0, excess};
	assign lc_ext     = {{(CALC_W-CHG_W){lc_new[CHG_W-1]}}, lc_new};
	assign rise_ext   = {{(CALC_W-RISE_W){1'b0}}, state_cur.rise_count};
	assign lvl_calc   = $signed({4'b0, BASE_LEVEL}) + excess_ext * EXCESS_GAIN
		+ lc_ext * CHANGE_GAIN + rise_ext;
	assign lvl        = excess_nz ? lvl_calc : $signed({4'b0, state_cur.fan_level});
	assign max_ext    = $signed({4'b0, cfg.max_level});

	always_comb begin
		if (lvl > max_ext)
			level_new = cfg.max_level;
		else if (lvl < $signed({4'b0, BASE_LEVEL}))
			level_new = BASE_LEVEL;
		else
			level_new = lvl[LEVEL_W-1:0];
	end

	always_comb begin
		rise_new = state_cur.rise_count;
		if (lc_new > 0) begin
			if (state_cur.rise_count < RISE_LIMIT)
				rise_new = state_cur.rise_count + 4'd1;
		end else if (lc_new < 0) begin
			if (state_cur.rise_count != '0)
				rise_new = state_cur.rise_count - 4'd1;
		end
	end

	// state update and drive request
	always_comb begin
		state_next = state_cur;
		drv_level  = '0;
		drv_req    = 1'b0;
		if (system_active) begin
			if (state_cur.previous_valid) begin
				state_next.fan_level   = level_new;
				state_next.rise_count  = rise_new;
				state_next.last_change = lc_new;
				drv_level              = level_new;
				drv_req                = cfg.update_enable;
			end
			state_next.previous_temp  = cur;
			state_next.previous_valid = 1'b1;
		end else if (state_cur.fan_level != '0) begin
			state_next             = STATE_RST;
			state_next.pwm_running = state_cur.pwm_running;
			drv_req                = cfg.update_enable;
		end

		full_on = {1'b0, drv_level} == ({1'b0, cfg.max_level} + 11'd1);
		res     = '0;
		emit    = 1'b0;
		if (drv_req) begin
			if (drv_level == '0) begin
				res.stop_old_pwm       = state_cur.pwm_running;
				state_next.pwm_running = 1'b0;
				emit                   = 1'b1;
			end else if (full_on) begin
				res.fan_on             = 1'b1;
				res.boost_enable       = 1'b1;
				res.stop_old_pwm       = state_cur.pwm_running;
				state_next.pwm_running = 1'b0;
				emit                   = 1'b1;
			end else if (drv_level <= cfg.max_level) begin
				res.fan_on             = 1'b1;
				res.boost_enable       = 1'b1;
				res.pwm_threshold      = drv_level;
				state_next.pwm_running = 1'b1;
				emit                   = 1'b1;
			end
		end
	end

endmodule

// File: rtl/thermal_fan_level_controller_core.sv
// ----------------------------------------------------------------------------
// thermal_fan_level_controller_core
// Flow: request into the s1 registers, combinational calc, result into res_q.
// Throughput: one request per cycle unless out_ready holds a result back.
// Reset: arst_n loads STATE_RST (last_change -1); max_level 255, update_enable 1.
// ----------------------------------------------------------------------------
module thermal_fan_level_controller_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tflc_pkg::APB_AW-1:0]        paddr,
	input  logic [tflc_pkg::APB_DW-1:0]        pwdata,
	output logic [tflc_pkg::APB_DW-1:0]        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [tflc_pkg::TEMP_W-1:0] temp_a,
	input  logic signed [tflc_pkg::TEMP_W-1:0] temp_b,
	input  logic signed [tflc_pkg::TEMP_W-1:0] temp_c,
	input  logic                               system_active,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               fan_on,
	output logic [tflc_pkg::LEVEL_W-1:0]       pwm_threshold,
	output logic                               boost_enable,
	output logic                               stop_old_pwm
);
	import tflc_pkg::*;

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_next;
	result_t res;
	result_t res_q;
	logic    emit;
	logic    out_valid_q;
	logic    valid_s1;
	logic    advance;

	logic signed [TEMP_W-1:0] temp_a_s1;
	logic signed [TEMP_W-1:0] temp_b_s1;
	logic signed [TEMP_W-1:0] temp_c_s1;
	logic                     active_s1;

	tflc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tflc_level_calc u_calc (
		.cfg           (cfg),
		.state_cur     (state_q),
		.temp_a        (temp_a_s1),
		.temp_b        (temp_b_s1),
		.temp_c        (temp_c_s1),
		.system_active (active_s1),
		.state_next    (state_next),
		.res           (res),
		.emit          (emit)
	);

	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			temp_a_s1 <= temp_a;
			temp_b_s1 <= temp_b;
			temp_c_s1 <= temp_c;
			active_s1 <= system_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_next;
			out_valid_q <= (advance & emit) | (out_valid_q & ~out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			res_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign fan_on        = res_q.fan_on;
	assign pwm_threshold = res_q.pwm_threshold;
	assign boost_enable  = res_q.boost_enable;
	assign stop_old_pwm  = res_q.stop_old_pwm;

endmodule

// File: sim/tflc_level_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tflc_level_checker
// Watches the register port and both request channels of the fan level
// controller. It keeps its own copy of the controller state and settings,
// predicts the drive result of every accepted tick and compares each accepted
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tflc_level_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic                               pready,
	input  logic [tflc_pkg::APB_AW-1:0]        paddr,
	input  logic [tflc_pkg::APB_DW-1:0]        pwdata,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic signed [tflc_pkg::TEMP_W-1:0] temp_a,
	input  logic signed [tflc_pkg::TEMP_W-1:0] temp_b,
	input  logic signed [tflc_pkg::TEMP_W-1:0] temp_c,
	input  logic                               system_active,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic                               fan_on,
	input  logic [tflc_pkg::LEVEL_W-1:0]       pwm_threshold,
	input  logic                               boost_enable,
	input  logic                               stop_old_pwm,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 checked
);
	import tflc_pkg::*;

	localparam int BASE        = int'(BASE_LEVEL);
	localparam int THRESH      = int'(FAN_START_TEMP);
	localparam int EXC_GAIN    = int'(EXCESS_GAIN);
	localparam int CHG_GAIN    = int'(CHANGE_GAIN);
	localparam int RISE_MAX    = int'(RISE_LIMIT);

	cfg_t    cfg_q;
	state_t  st;
	result_t expected_drive[$];
	result_t seen_res;
	result_t want_res;
	result_t tick_res;

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch, %s", $time, what);
		fail_count++;
	endtask

	function automatic bit drive_level(input int level, output result_t res);
		int cap;
		cap = int'(cfg_q.max_level);
		res = '0;
		if (level == 0) begin
			res.stop_old_pwm = st.pwm_running;
			st.pwm_running = 1'b0;
			return 1'b1;
		end
		// one above the cap: fan full on, PWM stopped
		if (level == cap + 1) begin
			res.fan_on = 1'b1;
			res.boost_enable = 1'b1;
			res.stop_old_pwm = st.pwm_running;
			st.pwm_running = 1'b0;
			return 1'b1;
		end
		if (level <= cap) begin
			res.fan_on = 1'b1;
			res.boost_enable = 1'b1;
			res.pwm_threshold = LEVEL_W'(level);
			st.pwm_running = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit predict_fan_tick(input logic signed [TEMP_W-1:0] ta, tb, tc,
			input logic act, output result_t res);
		int hot;
		int excess;
		int lvl;
		int rise;
		bit got;
		got = 1'b0;
		res = '0;
		if (act) begin
			hot = ta;
			if (tb > hot)
				hot = tb;
			if (tc > hot)
				hot = tc;
			if (st.previous_valid) begin
				excess = hot - THRESH;
				if (excess < 0)
					excess = 0;
				if (hot != int'($signed(st.previous_temp)))
					st.last_change = CHG_W'(hot - int'($signed(st.previous_temp)));
				lvl = int'(st.fan_level);
				if (excess != 0)
					lvl = BASE + excess * EXC_GAIN + int'($signed(st.last_change)) * CHG_GAIN
						+ int'(st.rise_count);
				if (lvl > int'(cfg_q.max_level))
					lvl = int'(cfg_q.max_level);
				else if (lvl < BASE)
					lvl = BASE;
				st.fan_level = LEVEL_W'(lvl);
				rise = int'(st.rise_count);
				if ($signed(st.last_change) > 0)
					rise++;
				else if ($signed(st.last_change) < 0)
					rise--;
				if (rise > RISE_MAX)
					rise = RISE_MAX;
				else if (rise < 0)
					rise = 0;
				st.rise_count = RISE_W'(rise);
				if (cfg_q.update_enable)
					got = drive_level(int'(st.fan_level), res);
			end
			st.previous_temp = TEMP_W'(hot);
			st.previous_valid = 1'b1;
		end else if (st.fan_level != '0) begin
			st.fan_level = '0;
			st.rise_count = '0;
			st.previous_temp = '0;
			st.previous_valid = 1'b0;
			st.last_change = '1;
			if (cfg_q.update_enable)
				got = drive_level(0, res);
		end
		return got;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st = STATE_RST;
			cfg_q = '{max_level: MAX_LEVEL_RST, update_enable: UPD_EN_RST};
			expected_drive.delete();
			fail_count = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				seen_res = '{fan_on: fan_on, pwm_threshold: pwm_threshold,
					boost_enable: boost_enable, stop_old_pwm: stop_old_pwm};
				if (expected_drive.size() == 0) begin
					report_mismatch($sformatf("result with none expected: on %0b thr %0d stop %0b",
						fan_on, pwm_threshold, stop_old_pwm));
				end else begin
					want_res = expected_drive.pop_front();
					checked++;
					if (seen_res.fan_on !== want_res.fan_on)
						report_mismatch($sformatf("fan_on %0b, expected %0b",
							seen_res.fan_on, want_res.fan_on));
					if (seen_res.pwm_threshold !== want_res.pwm_threshold)
						report_mismatch($sformatf("pwm_threshold %0d, expected %0d",
							seen_res.pwm_threshold, want_res.pwm_threshold));
					if (seen_res.boost_enable !== want_res.boost_enable)
						report_mismatch($sformatf("boost_enable %0b, expected %0b",
							seen_res.boost_enable, want_res.boost_enable));
					if (seen_res.stop_old_pwm !== want_res.stop_old_pwm)
						report_mismatch($sformatf("stop_old_pwm %0b, expected %0b",
							seen_res.stop_old_pwm, want_res.stop_old_pwm));
				end
			end
			if (in_valid && in_ready) begin
				if (predict_fan_tick(temp_a, temp_b, temp_c, system_active, tick_res))
					expected_drive.push_back(tick_res);
			end
			if (psel && penable && pwrite && pready) begin
				if ((paddr >> 2) == REG_MAX_LEVEL)
					cfg_q.max_level = pwdata[LEVEL_W-1:0];
				else if ((paddr >> 2) == REG_UPD_EN)
					cfg_q.update_enable = pwdata[0];
			end
			pending = expected_drive.size();
		end
	end

endmodule

// File: sim/thermal_fan_level_controller_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_fan_level_controller_core_tb
// Drives control ticks and register writes into the fan level controller.
// A short directed sequence is followed by random heating and cooling runs
// under a range of level caps, with updates on and off, with uneven idling
// on both channels and with none. Checking is done by tflc_level_checker.
// ----------------------------------------------------------------------------
module thermal_fan_level_controller_core_tb;
	import tflc_pkg::*;

	localparam int RESULT_LATENCY = 1;
	localparam int STALL_LIMIT    = 5000;

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      psel          = 1'b0;
	logic                      penable       = 1'b0;
	logic                      pwrite        = 1'b0;
	logic [APB_AW-1:0]         paddr         = '0;
	logic [APB_DW-1:0]         pwdata        = '0;
	logic [APB_DW-1:0]         prdata;
	logic                      pready;
	logic                      in_valid      = 1'b0;
	logic                      in_ready;
	logic signed [TEMP_W-1:0]  temp_a        = '0;
	logic signed [TEMP_W-1:0]  temp_b        = '0;
	logic signed [TEMP_W-1:0]  temp_c        = '0;
	logic                      system_active = 1'b0;
	logic                      out_valid;
	logic                      out_ready     = 1'b0;
	logic                      fan_on;
	logic [LEVEL_W-1:0]        pwm_threshold;
	logic                      boost_enable;
	logic                      stop_old_pwm;

	int snd_idle     = 9;
	int rcv_idle     = 62;
	int items_sent   = 0;
	int settings_done = 0;
	int quiet_cycles = 0;
	int fail_count;
	int pending;
	int checked;

	thermal_fan_level_controller_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.temp_a        (temp_a),
		.temp_b        (temp_b),
		.temp_c        (temp_c),
		.system_active (system_active),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.fan_on        (fan_on),
		.pwm_threshold (pwm_threshold),
		.boost_enable  (boost_enable),
		.stop_old_pwm  (stop_old_pwm)
	);

	tflc_level_checker u_tick_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.temp_a        (temp_a),
		.temp_b        (temp_b),
		.temp_c        (temp_c),
		.system_active (system_active),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.fan_on        (fan_on),
		.pwm_threshold (pwm_threshold),
		.boost_enable  (boost_enable),
		.stop_old_pwm  (stop_old_pwm),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("stalled for %0d cycles with %0d results outstanding", quiet_cycles, pending);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int clip_temp(input int v);
		return (v < -256) ? -256 : ((v > 255) ? 255 : v);
	endfunction

	task automatic send_tick(input int ta, input int tb, input int tc, input logic act);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		temp_a <= TEMP_W'(ta);
		temp_b <= TEMP_W'(tb);
		temp_c <= TEMP_W'(tc);
		system_active <= act;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	// hold off until every outstanding result is back and the pipe is empty
	task automatic drain_requests;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (RESULT_LATENCY + 1)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// upper data bits carry noise; the block keeps only the field width
	task automatic apply_setting(input int cap, input logic upd);
		drain_requests();
		write_reg(REG_MAX_LEVEL, ($urandom() & ~32'h3FF) | cap);
		write_reg(REG_UPD_EN, ($urandom() & ~32'h1) | upd);
		settings_done++;
	endtask

	task automatic run_random(input int quota);
		int counted;
		int seq_no;
		int len;
		int hot;
		int trend;
		int step;
		int lo1;
		int lo2;
		counted = 0;
		seq_no = 0;
		while (counted < quota) begin
			seq_no++;
			if (seq_no % 23 == 4)
				drain_requests();
			if ($urandom_range(99) < 12) begin
				send_tick($urandom_range(511), $urandom_range(511), $urandom_range(511),
					1'($urandom_range(1)));
				counted++;
			end else begin
				len = $urandom_range(30, 2);
				if ($urandom_range(9) == 0)
					hot = int'($urandom_range(511)) - 256;
				else
					hot = $urandom_range(110, 30);
				trend = int'($urandom_range(2)) - 1;
				repeat (len) begin
					lo1 = clip_temp(hot - int'($urandom_range(40)));
					lo2 = clip_temp(hot - int'($urandom_range(40)));
					case ($urandom_range(2))
						0: send_tick(hot, lo1, lo2, 1'b1);
						1: send_tick(lo1, hot, lo2, 1'b1);
						default: send_tick(lo1, lo2, hot, 1'b1);
					endcase
					counted++;
					if ($urandom_range(5) == 0)
						step = 0;
					else
						step = trend * int'($urandom_range(4)) + int'($urandom_range(2)) - 1;
					hot = clip_temp(hot + step);
				end
				// most runs end with the heat source switching off
				if ($urandom_range(9) < 8)
					send_tick($urandom_range(511), $urandom_range(511), $urandom_range(511), 1'b0);
			end
		end
	endtask

	initial begin
		repeat (12)
			@(negedge clk);
		arst_n <= 1'b1;

		send_tick(-256, -256, -256, 1'b1);
		send_tick(255, -256, -256, 1'b1);
		send_tick(-256, 255, 0, 1'b1);
		send_tick(0, -1, 255, 1'b1);
		send_tick(46, 46, 46, 1'b1);
		send_tick(45, 0, -256, 1'b1);
		send_tick(-256, -256, -256, 1'b1);
		send_tick(-256, -256, -256, 1'b1);
		send_tick(0, 0, 0, 1'b0);
		send_tick(0, 0, 0, 1'b0);
		send_tick(50, 50, 50, 1'b1);
		send_tick(50, 50, 50, 1'b1);
		for (int t = 52; t <= 72; t += 2)
			send_tick(t - 10, t, -256, 1'b1);
		send_tick(1, 2, 3, 1'b0);

		apply_setting(255, 1'b1);
		run_random(240);
		apply_setting(1023, 1'b1);
		run_random(240);
		apply_setting(128, 1'b1);
		run_random(240);

		snd_idle = 62;
		rcv_idle = 9;
		apply_setting(127, 1'b1);
		run_random(240);
		apply_setting(0, 1'b1);
		run_random(240);
		apply_setting(600, 1'b0);
		run_random(150);

		snd_idle = 0;
		rcv_idle = 0;
		apply_setting(100, 1'b1);
		run_random(240);
		apply_setting($urandom_range(1023), 1'b1);
		run_random(240);

		drain_requests();
		$display("%0d requests over %0d register settings, %0d results checked",
			items_sent, settings_done, checked);
		$display("caps from 0 to 1023, updates on and off, idling on either side and none");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
